// ===== rtl/swm_pkg.sv =====
`timescale 1ns / 1ps

package swm_pkg;

  localparam int unsigned SampleW = 32;
  localparam int unsigned CfgW    = 7;

  // Controller to datapath
  typedef struct packed {
    logic accept;     // input transaction taken this cycle
    logic rd_front;   // read the entry at the head
    logic rd_back;    // read the entry at the tail
    logic drop_head;  // drop the head entry
    logic drop_tail;  // drop the tail entry
    logic push;       // append the latched sample
    logic load_out;   // move the read value to the output register
  } swm_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic empty;          // deque holds no entry
    logic front_expired;  // entry read from the head has left the window
    logic back_smaller;   // entry read from the tail is below the sample
    logic full_window;    // window is full once the sample is pushed
  } swm_sts_t;

endpackage

// ===== rtl/swm_datapath.sv =====
`timescale 1ns / 1ps

module swm_datapath
  import swm_pkg::*;
#(
  parameter int unsigned WINDOW_MAX = 64
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_wr_en_i,
  input  logic [CfgW-1:0]           cfg_wr_data_i,
  input  logic                      start_of_sequence_i,
  input  logic signed [SampleW-1:0] sample_i,
  input  swm_cmd_t                  cmd_i,
  output swm_sts_t                  sts_o,
  output logic signed [SampleW-1:0] window_max_o
);

  localparam int unsigned IdxW   = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int unsigned CntW   = $clog2(WINDOW_MAX + 1);
  localparam int unsigned PosMod = 2 * WINDOW_MAX;
  localparam int unsigned PosW   = $clog2(PosMod);
  localparam int unsigned EntW   = SampleW + PosW;
  localparam int unsigned SumW   = CntW + 1;

  localparam logic [IdxW-1:0] LastIdx = IdxW'(WINDOW_MAX - 1);
  localparam logic [CntW-1:0] WinCnt  = CntW'(WINDOW_MAX);
  localparam logic [PosW-1:0] LastPos = PosW'(PosMod - 1);
  localparam logic [SumW-1:0] WinSum  = SumW'(WINDOW_MAX);

  logic [CfgW-1:0]           window_size_q;
  logic signed [SampleW-1:0] sample_q;
  logic [IdxW-1:0]           head_q;
  logic [CntW-1:0]           count_q;
  logic [PosW-1:0]           pos_q;
  logic [CntW-1:0]           fill_q;
  logic [EntW-1:0]           mem_q [WINDOW_MAX];
  logic [EntW-1:0]           rdata_q;
  logic signed [SampleW-1:0] window_max_q;

  logic [CntW-1:0]           win_k;
  logic [IdxW-1:0]           head_inc;
  logic [IdxW-1:0]           back_idx;
  logic [IdxW-1:0]           head_push;
  logic [CntW-1:0]           cnt_push;
  logic [IdxW-1:0]           slot_idx;
  logic [IdxW-1:0]           rd_addr;
  logic [SumW-1:0]           back_sum;
  logic [SumW-1:0]           slot_sum;
  logic [PosW:0]             age_diff;
  logic [PosW-1:0]           age;
  logic [PosW-1:0]           pos_inc;
  logic [CntW-1:0]           fill_next;
  logic signed [SampleW-1:0] rd_value;
  logic [PosW-1:0]           rd_pos;

  // Window size clamped to 1..WINDOW_MAX
  always_comb begin
    if (window_size_q == '0) begin
      win_k = CntW'(1);
    end else if (int'(window_size_q) > int'(WINDOW_MAX)) begin
      win_k = WinCnt;
    end else begin
      win_k = CntW'(window_size_q);
    end
  end

  assign head_inc = (head_q == LastIdx) ? '0 : head_q + IdxW'(1);
  assign pos_inc  = (pos_q == LastPos) ? '0 : pos_q + PosW'(1);

  assign back_sum = SumW'(head_q) + SumW'(count_q) - SumW'(1);
  assign back_idx = (back_sum >= WinSum) ? IdxW'(back_sum - WinSum) : IdxW'(back_sum);

  // A full deque cannot occur in normal use; make room at the head if it does
  always_comb begin
    if (count_q == WinCnt) begin
      head_push = head_inc;
      cnt_push  = WinCnt - CntW'(1);
    end else begin
      head_push = head_q;
      cnt_push  = count_q;
    end
  end

  assign slot_sum = SumW'(head_push) + SumW'(cnt_push);
  assign slot_idx = (slot_sum >= WinSum) ? IdxW'(slot_sum - WinSum) : IdxW'(slot_sum);

  assign rd_addr  = cmd_i.rd_back ? back_idx : head_q;
  assign rd_value = $signed(rdata_q[EntW-1:PosW]);
  assign rd_pos   = rdata_q[PosW-1:0];

  // Age of the head entry, modulo the position range
  always_comb begin
    age_diff = {1'b0, pos_q} - {1'b0, rd_pos};
    if (age_diff[PosW]) begin
      age = PosW'(age_diff + (PosW + 1)'(PosMod));
    end else begin
      age = age_diff[PosW-1:0];
    end
  end

  assign fill_next = (fill_q < win_k) ? fill_q + CntW'(1) : win_k;

  assign sts_o.empty         = (count_q == '0);
  assign sts_o.front_expired = (age >= PosW'(win_k));
  assign sts_o.back_smaller  = (rd_value < sample_q);
  assign sts_o.full_window   = (fill_next == win_k);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_size_q <= CfgW'(1);
    end else if (cfg_wr_en_i) begin
      window_size_q <= cfg_wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
      pos_q   <= '0;
      fill_q  <= '0;
    end else if (cmd_i.accept && start_of_sequence_i) begin
      head_q  <= '0;
      count_q <= '0;
      pos_q   <= '0;
      fill_q  <= '0;
    end else if (cmd_i.drop_head) begin
      head_q  <= head_inc;
      count_q <= count_q - CntW'(1);
    end else if (cmd_i.drop_tail) begin
      count_q <= count_q - CntW'(1);
    end else if (cmd_i.push) begin
      head_q  <= head_push;
      count_q <= cnt_push + CntW'(1);
      pos_q   <= pos_inc;
      fill_q  <= fill_next;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      sample_q <= sample_i;
    end
    if (cmd_i.load_out) begin
      window_max_q <= rd_value;
    end
  end

  // Candidate store: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      mem_q[slot_idx] <= {sample_q, pos_q};
    end
    if (cmd_i.rd_front || cmd_i.rd_back) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  assign window_max_o = window_max_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= WinCnt)
    else $error("deque count above capacity");

  a_head_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(head_q) < int'(WINDOW_MAX))
    else $error("deque head outside ring");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.drop_head || cmd_i.drop_tail) |-> count_q != '0)
    else $error("pop from empty deque");

  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.push && count_q != WinCnt) |=> count_q == $past(count_q) + CntW'(1))
    else $error("push did not grow the deque");

endmodule

// ===== rtl/swm_ctrl.sv =====
`timescale 1ns / 1ps

module swm_ctrl
  import swm_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  input  swm_sts_t sts_i,
  output swm_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FRONT_RD,
    ST_FRONT_CHK,
    ST_BACK_RD,
    ST_BACK_CHK,
    ST_PUSH,
    ST_OUT_RD,
    ST_OUT_LOAD
  } state_e;

  state_e state_q;
  logic   out_valid_q;

  always_comb begin
    cmd_o = '0;
    case (state_q)
      ST_IDLE:      cmd_o.accept    = in_valid_i;
      ST_FRONT_RD:  cmd_o.rd_front  = !sts_i.empty;
      ST_FRONT_CHK: cmd_o.drop_head = sts_i.front_expired;
      ST_BACK_RD:   cmd_o.rd_back   = !sts_i.empty;
      ST_BACK_CHK:  cmd_o.drop_tail = sts_i.back_smaller;
      ST_PUSH:      cmd_o.push      = 1'b1;
      ST_OUT_RD:    cmd_o.rd_front  = 1'b1;
      ST_OUT_LOAD:  cmd_o.load_out  = !out_valid_q || !out_stall_i;
      default:      cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) state_q <= ST_FRONT_RD;
        end
        ST_FRONT_RD: begin
          // empty deque: nothing to drop or pop
          state_q <= sts_i.empty ? ST_PUSH : ST_FRONT_CHK;
        end
        ST_FRONT_CHK: begin
          state_q <= sts_i.front_expired ? ST_FRONT_RD : ST_BACK_RD;
        end
        ST_BACK_RD: begin
          state_q <= sts_i.empty ? ST_PUSH : ST_BACK_CHK;
        end
        ST_BACK_CHK: begin
          state_q <= sts_i.back_smaller ? ST_BACK_RD : ST_PUSH;
        end
        ST_PUSH: begin
          state_q <= sts_i.full_window ? ST_OUT_RD : ST_IDLE;
        end
        ST_OUT_RD: begin
          state_q <= ST_OUT_LOAD;
        end
        ST_OUT_LOAD: begin
          if (cmd_o.load_out) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !cmd_o.load_out)
    else $error("result overwritten while stalled");

  a_one_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.accept, cmd_o.rd_front, cmd_o.rd_back, cmd_o.drop_head,
              cmd_o.drop_tail, cmd_o.push, cmd_o.load_out}))
    else $error("more than one datapath command");

  a_push_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.push |=> (state_q == ST_IDLE || state_q == ST_OUT_RD))
    else $error("push not followed by finish or result read");

endmodule

// ===== rtl/sliding_window_maximum.sv =====
`timescale 1ns / 1ps
// Channel  Direction  Handshake               Payload
// cfg      in         cfg_wr_en_i             cfg_wr_data_i (window_size)
// in       in         in_valid_i/in_stall_o   start_of_sequence_i, sample_i
// out      out        out_valid_o/out_stall_i window_max_o
//
// Per sample: accept, head tests, tail tests, push; each test that reads an entry
// is a registered memory read, then a compare, and a test that finds the deque
// empty goes straight to the push. With a full window the head is then read and
// loaded as the maximum. Reset clears the deque and sets window_size to 1.
// A result waits under out_stall_i while the next sample is accepted; the next
// result is held back until that one is taken.

module sliding_window_maximum
  import swm_pkg::*;
#(
  parameter int unsigned WINDOW_MAX = 64
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_wr_en_i,
  input  logic [CfgW-1:0]           cfg_wr_data_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic                      start_of_sequence_i,
  input  logic signed [SampleW-1:0] sample_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic signed [SampleW-1:0] window_max_o
);

  swm_cmd_t cmd;
  swm_sts_t sts;

  swm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  swm_datapath #(
    .WINDOW_MAX (WINDOW_MAX)
  ) u_datapath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_wr_en_i         (cfg_wr_en_i),
    .cfg_wr_data_i       (cfg_wr_data_i),
    .start_of_sequence_i (start_of_sequence_i),
    .sample_i            (sample_i),
    .cmd_i               (cmd),
    .sts_o               (sts),
    .window_max_o        (window_max_o)
  );

endmodule
